// ===== design/hrsp_pkg.sv =====
// Package for the HTTP request stream parser: phase codes, result codes,
// state and result structs, and the method and HTTP literal character tables.
// No dependencies.
package hrsp_pkg;

   typedef enum logic [3:0] {
      PH_M_FIRST  = 4'd0,
      PH_M_REST   = 4'd1,
      PH_M_SPACE  = 4'd2,
      PH_TARGET   = 4'd3,
      PH_HTTP     = 4'd4,
      PH_VERSION  = 4'd5,
      PH_RL_CR    = 4'd6,
      PH_RL_LF    = 4'd7,
      PH_LINE     = 4'd8,
      PH_LINE_CR  = 4'd9,
      PH_NAME     = 4'd10,
      PH_VSPACE   = 4'd11,
      PH_VALUE    = 4'd12,
      PH_VALUE_LF = 4'd13,
      PH_BODY     = 4'd14,
      PH_ERROR    = 4'd15
   } phase_type;

   // byte roles
   localparam logic [2:0] ROLE_SYNTAX  = 3'd0;
   localparam logic [2:0] ROLE_METHOD  = 3'd1;
   localparam logic [2:0] ROLE_TARGET  = 3'd2;
   localparam logic [2:0] ROLE_VERSION = 3'd3;
   localparam logic [2:0] ROLE_NAME    = 3'd4;
   localparam logic [2:0] ROLE_VALUE   = 3'd5;
   localparam logic [2:0] ROLE_BODY    = 3'd6;
   localparam logic [2:0] ROLE_IGNORED = 3'd7;

   // methods
   localparam logic [2:0] METH_NONE   = 3'd0;
   localparam logic [2:0] METH_GET    = 3'd1;
   localparam logic [2:0] METH_POST   = 3'd2;
   localparam logic [2:0] METH_PUT    = 3'd3;
   localparam logic [2:0] METH_PATCH  = 3'd4;
   localparam logic [2:0] METH_DELETE = 3'd5;
   localparam logic [2:0] METH_HEAD   = 3'd6;

   // versions
   localparam logic [1:0] VER_NONE = 2'd0;
   localparam logic [1:0] VER_0_9  = 2'd1;
   localparam logic [1:0] VER_1_0  = 2'd2;
   localparam logic [1:0] VER_1_1  = 2'd3;

   // status
   localparam logic [2:0] ST_RUN      = 3'd0;
   localparam logic [2:0] ST_DONE     = 3'd1;
   localparam logic [2:0] ST_BAD_METH = 3'd2;
   localparam logic [2:0] ST_BAD_VER  = 3'd3;
   localparam logic [2:0] ST_BAD_FMT  = 3'd4;
   localparam logic [2:0] ST_TRUNC    = 3'd5;

   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_COLON = 8'h3A;

   localparam logic [2:0] HTTP_LEN = 3'd5;
   localparam logic [2:0] VER_LEN  = 3'd3;

   typedef struct packed {
      phase_type  phase;
      logic [2:0] pos;
      logic [2:0] meth;
      logic [1:0] ver;
      logic [2:0] err;
   } state_type;

   typedef struct packed {
      logic [2:0] role;
      logic [2:0] meth;
      logic [1:0] ver;
      logic [2:0] status;
      logic       last;
   } result_type;

   function automatic logic [2:0] meth_len(input logic [2:0] m);
      logic [2:0] len;
      case (m)
         METH_GET:    len = 3'd3;
         METH_POST:   len = 3'd4;
         METH_PUT:    len = 3'd3;
         METH_PATCH:  len = 3'd5;
         METH_DELETE: len = 3'd6;
         METH_HEAD:   len = 3'd4;
         default:     len = 3'd0;
      endcase
      return len;
   endfunction

   function automatic logic [7:0] meth_char(input logic [2:0] m, input logic [2:0] p);
      logic [7:0] c;
      c = 8'h00;
      case (m)
         METH_GET: begin
            case (p)
               3'd0: c = "G"; 3'd1: c = "E"; 3'd2: c = "T";
               default: c = 8'h00;
            endcase
         end
         METH_POST: begin
            case (p)
               3'd0: c = "P"; 3'd1: c = "O"; 3'd2: c = "S"; 3'd3: c = "T";
               default: c = 8'h00;
            endcase
         end
         METH_PUT: begin
            case (p)
               3'd0: c = "P"; 3'd1: c = "U"; 3'd2: c = "T";
               default: c = 8'h00;
            endcase
         end
         METH_PATCH: begin
            case (p)
               3'd0: c = "P"; 3'd1: c = "A"; 3'd2: c = "T"; 3'd3: c = "C";
               3'd4: c = "H";
               default: c = 8'h00;
            endcase
         end
         METH_DELETE: begin
            case (p)
               3'd0: c = "D"; 3'd1: c = "E"; 3'd2: c = "L"; 3'd3: c = "E";
               3'd4: c = "T"; 3'd5: c = "E";
               default: c = 8'h00;
            endcase
         end
         METH_HEAD: begin
            case (p)
               3'd0: c = "H"; 3'd1: c = "E"; 3'd2: c = "A"; 3'd3: c = "D";
               default: c = 8'h00;
            endcase
         end
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] http_char(input logic [2:0] p);
      logic [7:0] c;
      case (p)
         3'd0:    c = "H";
         3'd1:    c = "T";
         3'd2:    c = "T";
         3'd3:    c = "P";
         3'd4:    c = "/";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

// ===== design/hrsp_step.sv =====
// Combinational parse step: next parser state and the result for one byte.
// Depends on hrsp_pkg.
module hrsp_step (
   input  hrsp_pkg::state_type  cur,
   input  logic [7:0]           data_byte,
   input  logic                 last,
   output hrsp_pkg::state_type  nxt,
   output hrsp_pkg::result_type res
);

   hrsp_pkg::state_type upd;
   logic [2:0]          role;
   logic [2:0]          m;
   logic [2:0]          p;
   logic                ok;
   logic [2:0]          status;

   always_comb begin
      upd  = cur;
      role = hrsp_pkg::ROLE_SYNTAX;
      m    = cur.meth;
      p    = cur.pos;
      ok   = 1'b1;

      unique case (cur.phase) inside
         hrsp_pkg::PH_M_FIRST: begin
            role = hrsp_pkg::ROLE_METHOD;
            case (data_byte)
               "G":     m = hrsp_pkg::METH_GET;
               "P":     m = hrsp_pkg::METH_POST;
               "D":     m = hrsp_pkg::METH_DELETE;
               "H":     m = hrsp_pkg::METH_HEAD;
               default: m = hrsp_pkg::METH_NONE;
            endcase
            upd.meth = m;
            if (m == hrsp_pkg::METH_NONE) begin
               role      = hrsp_pkg::ROLE_IGNORED;
               upd.phase = hrsp_pkg::PH_ERROR;
               upd.err   = hrsp_pkg::ST_BAD_METH;
               upd.pos   = 3'd0;
            end else begin
               upd.pos   = 3'd1;
               upd.phase = hrsp_pkg::PH_M_REST;
            end
         end
         hrsp_pkg::PH_M_REST: begin
            role = hrsp_pkg::ROLE_METHOD;
            // second letter tells POST, PUT and PATCH apart
            if (m >= hrsp_pkg::METH_POST && m <= hrsp_pkg::METH_PATCH && p == 3'd1) begin
               case (data_byte)
                  "O":     m = hrsp_pkg::METH_POST;
                  "U":     m = hrsp_pkg::METH_PUT;
                  "A":     m = hrsp_pkg::METH_PATCH;
                  default: m = hrsp_pkg::METH_NONE;
               endcase
            end else if (m < hrsp_pkg::METH_GET || m > hrsp_pkg::METH_HEAD ||
                         p >= hrsp_pkg::meth_len(m) ||
                         hrsp_pkg::meth_char(m, p) != data_byte) begin
               m = hrsp_pkg::METH_NONE;
            end
            upd.meth = m;
            if (m == hrsp_pkg::METH_NONE) begin
               role      = hrsp_pkg::ROLE_IGNORED;
               upd.phase = hrsp_pkg::PH_ERROR;
               upd.err   = hrsp_pkg::ST_BAD_METH;
               upd.pos   = 3'd0;
            end else if (p + 3'd1 >= hrsp_pkg::meth_len(m)) begin
               upd.pos   = 3'd0;
               upd.phase = hrsp_pkg::PH_M_SPACE;
            end else begin
               upd.pos = p + 3'd1;
            end
         end
         hrsp_pkg::PH_M_SPACE: begin
            if (data_byte == hrsp_pkg::CH_SP) begin
               upd.phase = hrsp_pkg::PH_TARGET;
            end else begin
               role      = hrsp_pkg::ROLE_IGNORED;
               upd.phase = hrsp_pkg::PH_ERROR;
               upd.err   = hrsp_pkg::ST_BAD_FMT;
               upd.pos   = 3'd0;
            end
         end
         hrsp_pkg::PH_TARGET: begin
            if (data_byte == hrsp_pkg::CH_SP) begin
               upd.phase = hrsp_pkg::PH_HTTP;
               upd.pos   = 3'd0;
            end else begin
               role = hrsp_pkg::ROLE_TARGET;
            end
         end
         hrsp_pkg::PH_HTTP: begin
            role = hrsp_pkg::ROLE_VERSION;
            if (p >= hrsp_pkg::HTTP_LEN || hrsp_pkg::http_char(p) != data_byte) begin
               role      = hrsp_pkg::ROLE_IGNORED;
               upd.phase = hrsp_pkg::PH_ERROR;
               upd.err   = hrsp_pkg::ST_BAD_VER;
               upd.pos   = 3'd0;
            end else if (p + 3'd1 == hrsp_pkg::HTTP_LEN) begin
               upd.pos   = 3'd0;
               upd.phase = hrsp_pkg::PH_VERSION;
            end else begin
               upd.pos = p + 3'd1;
            end
         end
         hrsp_pkg::PH_VERSION: begin
            role = hrsp_pkg::ROLE_VERSION;
            if (p == 3'd0) begin
               if (data_byte == "0") upd.ver = hrsp_pkg::VER_0_9;
               else if (data_byte == "1") upd.ver = hrsp_pkg::VER_1_0;
               else ok = 1'b0;
            end else if (p == 3'd1) begin
               ok = (data_byte == ".");
            end else if (cur.ver == hrsp_pkg::VER_0_9) begin
               ok = (data_byte == "9");
            end else if (cur.ver == hrsp_pkg::VER_1_0 &&
                         (data_byte == "0" || data_byte == "1")) begin
               upd.ver = (data_byte == "0") ? hrsp_pkg::VER_1_0 : hrsp_pkg::VER_1_1;
            end else begin
               ok = 1'b0;
            end
            if (!ok) begin
               upd.ver   = hrsp_pkg::VER_NONE;
               role      = hrsp_pkg::ROLE_IGNORED;
               upd.phase = hrsp_pkg::PH_ERROR;
               upd.err   = hrsp_pkg::ST_BAD_VER;
               upd.pos   = 3'd0;
            end else if (p + 3'd1 >= hrsp_pkg::VER_LEN) begin
               upd.pos   = 3'd0;
               upd.phase = hrsp_pkg::PH_RL_CR;
            end else begin
               upd.pos = p + 3'd1;
            end
         end
         hrsp_pkg::PH_RL_CR: begin
            if (data_byte == hrsp_pkg::CH_CR) begin
               upd.phase = hrsp_pkg::PH_RL_LF;
            end else begin
               role      = hrsp_pkg::ROLE_IGNORED;
               upd.phase = hrsp_pkg::PH_ERROR;
               upd.err   = hrsp_pkg::ST_BAD_FMT;
               upd.pos   = 3'd0;
            end
         end
         hrsp_pkg::PH_RL_LF, hrsp_pkg::PH_VALUE_LF: begin
            if (data_byte == hrsp_pkg::CH_LF) begin
               upd.phase = hrsp_pkg::PH_LINE;
            end else begin
               role      = hrsp_pkg::ROLE_IGNORED;
               upd.phase = hrsp_pkg::PH_ERROR;
               upd.err   = hrsp_pkg::ST_BAD_FMT;
               upd.pos   = 3'd0;
            end
         end
         hrsp_pkg::PH_LINE: begin
            if (data_byte == hrsp_pkg::CH_CR) begin
               upd.phase = hrsp_pkg::PH_LINE_CR;
            end else if (data_byte == hrsp_pkg::CH_COLON) begin
               upd.phase = hrsp_pkg::PH_VSPACE;
            end else begin
               role      = hrsp_pkg::ROLE_NAME;
               upd.phase = hrsp_pkg::PH_NAME;
            end
         end
         hrsp_pkg::PH_LINE_CR: begin
            // a lone CR at line start falls into the header name
            if (data_byte == hrsp_pkg::CH_LF) begin
               upd.phase = hrsp_pkg::PH_BODY;
            end else if (data_byte == hrsp_pkg::CH_COLON) begin
               upd.phase = hrsp_pkg::PH_VSPACE;
            end else begin
               role      = hrsp_pkg::ROLE_NAME;
               upd.phase = hrsp_pkg::PH_NAME;
            end
         end
         hrsp_pkg::PH_NAME: begin
            if (data_byte == hrsp_pkg::CH_COLON) upd.phase = hrsp_pkg::PH_VSPACE;
            else role = hrsp_pkg::ROLE_NAME;
         end
         hrsp_pkg::PH_VSPACE: begin
            if (data_byte == hrsp_pkg::CH_SP) begin
               upd.phase = hrsp_pkg::PH_VSPACE;
            end else if (data_byte == hrsp_pkg::CH_CR) begin
               upd.phase = hrsp_pkg::PH_VALUE_LF;
            end else begin
               role      = hrsp_pkg::ROLE_VALUE;
               upd.phase = hrsp_pkg::PH_VALUE;
            end
         end
         hrsp_pkg::PH_VALUE: begin
            if (data_byte == hrsp_pkg::CH_CR) upd.phase = hrsp_pkg::PH_VALUE_LF;
            else role = hrsp_pkg::ROLE_VALUE;
         end
         hrsp_pkg::PH_BODY: begin
            role = hrsp_pkg::ROLE_BODY;
         end
         default: begin
            role = hrsp_pkg::ROLE_IGNORED;
         end
      endcase

      if (upd.phase == hrsp_pkg::PH_ERROR) status = upd.err;
      else if (upd.phase == hrsp_pkg::PH_BODY) status = hrsp_pkg::ST_DONE;
      else status = last ? hrsp_pkg::ST_TRUNC : hrsp_pkg::ST_RUN;

      res.role   = role;
      res.meth   = (upd.phase >= hrsp_pkg::PH_M_SPACE) ? upd.meth : hrsp_pkg::METH_NONE;
      res.ver    = (upd.phase >= hrsp_pkg::PH_RL_CR) ? upd.ver : hrsp_pkg::VER_NONE;
      res.status = status;
      res.last   = last;

      // the final byte of a request returns the parser to its start
      if (last) begin
         nxt.phase = hrsp_pkg::PH_M_FIRST;
         nxt.pos   = 3'd0;
         nxt.meth  = hrsp_pkg::METH_NONE;
         nxt.ver   = hrsp_pkg::VER_NONE;
         nxt.err   = hrsp_pkg::ST_RUN;
      end else begin
         nxt = upd;
      end
   end

endmodule

// ===== design/hrsp_skid.sv =====
// Two-entry result buffer: output register plus skid register.
// Depends on hrsp_pkg.
module hrsp_skid (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   input  hrsp_pkg::result_type push_data,
   output logic                 full,
   output logic                 out_valid,
   input  logic                 out_ready,
   output hrsp_pkg::result_type out_data
);

   logic                 main_valid_ff, main_valid_in;
   logic                 skid_valid_ff, skid_valid_in;
   hrsp_pkg::result_type main_ff, main_in;
   hrsp_pkg::result_type skid_ff, skid_in;
   logic                 pop;

   assign pop       = main_valid_ff && out_ready;
   assign full      = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = push_valid;
            main_in       = push_data;
         end
      end else if (!main_valid_ff) begin
         main_valid_in = push_valid;
         main_in       = push_data;
      end else if (push_valid) begin
         skid_valid_in = 1'b1;
         skid_in       = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

// ===== design/http_request_stream_parser.sv =====
// Top level of the HTTP request stream parser: input register, parser state,
// parse step and result buffer. Depends on hrsp_pkg, hrsp_step, hrsp_skid.
//
//  channel | dir | ports                         | payload
//  --------+-----+-------------------------------+----------------------------------
//  req     | in  | req_tvalid/tready/tdata/tlast | tdata = data_byte, tlast = end
//  rsp     | out | rsp_tvalid/tready/tdata/tuser | tuser = byte_role,
//          |     | rsp_tlast                     | tdata = method, version, status
//
// One transfer in, one transfer out per byte; sustained rate is one byte per
// cycle while rsp_tready is high; bytes pass the input, then the result register.
// The parse step is a single combinational pass over the parser state registers.
// Reset is synchronous and active high; it clears the parser state and all
// valid flags.
// A stalled result is held in the output register; one more result fits in the
// skid register, so req_tready drops only once both are occupied and the input
// register holds a byte as well.
module http_request_stream_parser (
   input  logic       clock,
   input  logic       reset,

   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tlast,   // end_of_request

   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [2:0] method_code, [4:3] version_code, [7:5] parse_status
   output logic [2:0] rsp_tuser,   // [2:0] byte_role
   output logic       rsp_tlast    // last_result
);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   // parser state
   hrsp_pkg::state_type  state_ff, state_in;
   hrsp_pkg::result_type step_res;
   hrsp_pkg::result_type out_res;

   logic skid_full;
   logic adv;
   logic req_xfer;

   // advance the held byte into the result buffer whenever there is room
   assign adv        = in_valid_ff && !skid_full;
   assign req_tready = !in_valid_ff || adv;
   assign req_xfer   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_xfer) in_valid_in = 1'b1;
      else if (adv) in_valid_in = 1'b0;
   end

   hrsp_step u_step (
      .cur       (state_ff),
      .data_byte (in_byte_ff),
      .last      (in_last_ff),
      .nxt       (state_in),
      .res       (step_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         state_ff.phase <= hrsp_pkg::PH_M_FIRST;
         state_ff.pos   <= 3'd0;
         state_ff.meth  <= hrsp_pkg::METH_NONE;
         state_ff.ver   <= hrsp_pkg::VER_NONE;
         state_ff.err   <= hrsp_pkg::ST_RUN;
      end else begin
         in_valid_ff <= in_valid_in;
         // commit the parser state only when the byte moves on
         if (adv) state_ff <= state_in;
      end
      // hold the payload until the next transfer
      if (req_xfer) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   hrsp_skid u_skid (
      .clock      (clock),
      .reset      (reset),
      .push_valid (adv),
      .push_data  (step_res),
      .full       (skid_full),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_data   (out_res)
   );

   assign rsp_tuser = out_res.role;
   assign rsp_tdata = {out_res.status, out_res.ver, out_res.meth};
   assign rsp_tlast = out_res.last;

   // a byte that advances always leaves a result waiting
   assert property (@(posedge clock) disable iff (reset) adv |=> rsp_tvalid)
      else $error("advanced byte produced no result");

   // the final byte of a request returns the parser to its start state
   assert property (@(posedge clock) disable iff (reset)
      (adv && in_last_ff) |=> (state_ff.phase == hrsp_pkg::PH_M_FIRST &&
                               state_ff.meth == hrsp_pkg::METH_NONE &&
                               state_ff.err == hrsp_pkg::ST_RUN))
      else $error("parser state not cleared after final byte");

   // an error code is latched only while the parser sits in the error phase
   assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase != hrsp_pkg::PH_ERROR) |-> (state_ff.err == hrsp_pkg::ST_RUN))
      else $error("error code latched outside the error phase");

   // the skid register fills only behind an occupied output register
   assert property (@(posedge clock) disable iff (reset) skid_full |-> rsp_tvalid)
      else $error("skid register full with empty output register");

endmodule
